>>> design/rrbb_pkg.sv
// Shared types, widths and constants for the rotated rectangle bounding box core.
package rrbb_pkg;

   // Field widths
   localparam int COORD_W     = 24;
   localparam int SIZE_W      = 12;
   localparam int SCALE_W     = 12;
   localparam int ANGLE_W     = 15;

   // Fixed-point formats
   localparam int FRAC_BITS   = 8;
   localparam int TRIG_BITS   = 16;
   localparam int TRIG_F      = TRIG_BITS - 1;
   localparam int CORD_MAX_IT = 24;
   localparam int CORD_ITERS  = (TRIG_BITS > CORD_MAX_IT) ? CORD_MAX_IT : TRIG_BITS;

   // Internal widths
   localparam int Z_W         = 24;
   localparam int XY_W        = TRIG_BITS + 2;
   localparam int TRIG_W      = TRIG_BITS + 1;
   localparam int SIZE_PROD_W = SIZE_W + SCALE_W;
   localparam int PROD_W      = SIZE_PROD_W + 1 + TRIG_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int RND_SH      = 9 + TRIG_F - FRAC_BITS;
   localparam int OFS_W       = SUM_W - RND_SH;
   localparam int CORNER_W    = OFS_W + 1;

   // Angle handling, 1/64 degree units in, 1/16384 degree units in the rotator
   localparam logic [ANGLE_W-1:0] FULL_TURN    = ANGLE_W'(23040);
   localparam logic [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(11520);
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(5760);
   localparam int ANGLE_SH = 8;

   // CORDIC start vector, gain rounded half up to TRIG_F fraction bits
   localparam longint GAIN_Q30 = 652032874;
   localparam logic signed [XY_W-1:0] CORD_GAIN =
      XY_W'((GAIN_Q30 + (longint'(1) << (29 - TRIG_F))) >> (30 - TRIG_F));
   localparam logic signed [XY_W-1:0] TRIG_ONE = XY_W'(longint'(1) << TRIG_F);

   // atan(2^-i) in 1/16384 degree
   localparam logic signed [Z_W-1:0] ATAN_TAB [CORD_MAX_IT] = '{
      737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
      3667, 1833, 917, 458, 229, 115, 57, 29,
      14, 7, 4, 2, 1, 0, 0, 0
   };

   // Rounding of the corner offsets
   localparam logic signed [SUM_W-1:0] RND_HALF =
      (RND_SH > 0) ? SUM_W'(longint'(1) << ((RND_SH > 0) ? RND_SH - 1 : 0)) : '0;

   localparam logic signed [CORNER_W-1:0] COORD_MAX = CORNER_W'(8388607);
   localparam logic signed [CORNER_W-1:0] COORD_MIN = -CORNER_W'(8388608);

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_SCALE_FACTOR = 1'b0;
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

   // Per-item data that rides along the rotator
   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [SIZE_PROD_W-1:0]    w;
      logic [SIZE_PROD_W-1:0]    h;
      logic                      neg;
   } side_type;

endpackage

>>> design/rotated_rect_bounding_box_core.sv
// Top level: axis-aligned bounding box of a rotated, scaled rectangle.
// Stages from input accept to rsp_tvalid: 2 prep stages, 16 CORDIC stages,
// clamp, multiply, round, saturate, min/max. Throughput: one item per cycle
// while rsp_tready does not stall the output; every stage has its own valid
// bit, so bubbles close up under a stall. Reset (synchronous, active high)
// empties the pipeline and sets scale_factor to 1.0 (256); payload registers are not reset.
module rotated_rect_bounding_box_core import rrbb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // center_x[23:0], center_y[47:24], tex_width[59:48], tex_height[71:60],
   // angle[86:72], zero pad[87]
   input  logic [87:0]           req_tdata,
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // min_x[23:0], min_y[47:24], max_x[71:48], max_y[95:72]
   output logic [95:0]           rsp_tdata,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------- CSR
   logic [SCALE_W-1:0] scale_ff;
   logic               csr_hit;

   assign csr_hit    = (csr_paddr[2] == REG_SCALE_FACTOR);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(scale_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         scale_ff <= csr_pwdata[SCALE_W-1:0];
      end
   end

   // ---------------------------------------------------------------- handshake
   // Each stage loads when it is empty or its successor loads.
   logic va_ff, vb_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff;
   logic rdy_a, rdy_b, rdy_d, rdy_e, rdy_f, rdy_g, rdy_h;
   logic cord_in_ready, cord_out_valid;

   assign rdy_h = !vh_ff || rsp_tready;
   assign rdy_g = !vg_ff || rdy_h;
   assign rdy_f = !vf_ff || rdy_g;
   assign rdy_e = !ve_ff || rdy_f;
   assign rdy_d = !vd_ff || rdy_e;
   assign rdy_b = !vb_ff || cord_in_ready;
   assign rdy_a = !va_ff || rdy_b;

   assign req_tready = rdy_a;
   assign rsp_tvalid = vh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_tvalid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_d) vd_ff <= cord_out_valid;
         if (rdy_e) ve_ff <= vd_ff;
         if (rdy_f) vf_ff <= ve_ff;
         if (rdy_g) vg_ff <= vf_ff;
         if (rdy_h) vh_ff <= vg_ff;
      end
   end

   // ---------------------------------------------------------------- stage A
   // Unpack, scale the sizes, wrap the angle into one turn.
   side_type           side_a_ff, side_a_in;
   logic [ANGLE_W-1:0] ang_a_ff, ang_a_in, req_angle;

   assign req_angle = req_tdata[86:72];

   always_comb begin
      side_a_in.cx  = req_tdata[23:0];
      side_a_in.cy  = req_tdata[47:24];
      side_a_in.w   = SIZE_PROD_W'(req_tdata[59:48]) * SIZE_PROD_W'(scale_ff);
      side_a_in.h   = SIZE_PROD_W'(req_tdata[71:60]) * SIZE_PROD_W'(scale_ff);
      side_a_in.neg = 1'b0;
      ang_a_in      = (req_angle >= FULL_TURN) ? req_angle - FULL_TURN : req_angle;
   end

   always_ff @(posedge clock) begin
      if (rdy_a && req_tvalid) begin
         side_a_ff <= side_a_in;
         ang_a_ff  <= ang_a_in;
      end
   end

   // ---------------------------------------------------------------- stage B
   // Fold into [-90, 90) degrees; the folded half turn negates both results.
   side_type               side_b_ff, side_b_in;
   logic signed [Z_W-1:0]  z_b_ff, z_b_in;
   logic [ANGLE_W:0]       fold_u;

   always_comb begin
      side_b_in = side_a_ff;
      if (ang_a_ff >= QUARTER_TURN && ang_a_ff < FULL_TURN - QUARTER_TURN) begin
         fold_u        = {1'b0, ang_a_ff} - {1'b0, HALF_TURN};
         side_b_in.neg = 1'b1;
      end else if (ang_a_ff >= FULL_TURN - QUARTER_TURN) begin
         fold_u = {1'b0, ang_a_ff} - {1'b0, FULL_TURN};
      end else begin
         fold_u = {1'b0, ang_a_ff};
      end
      z_b_in = Z_W'($signed(fold_u)) <<< ANGLE_SH;
   end

   always_ff @(posedge clock) begin
      if (rdy_b && va_ff) begin
         side_b_ff <= side_b_in;
         z_b_ff    <= z_b_in;
      end
   end

   // ---------------------------------------------------------------- CORDIC
   logic signed [XY_W-1:0] cord_x, cord_y;
   side_type               cord_side;

   rrbb_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vb_ff),
      .in_ready  (cord_in_ready),
      .in_z      (z_b_ff),
      .in_side   (side_b_ff),
      .out_valid (cord_out_valid),
      .out_ready (rdy_d),
      .out_x     (cord_x),
      .out_y     (cord_y),
      .out_side  (cord_side)
   );

   // ---------------------------------------------------------------- stage D
   // Undo the fold and clamp cos/sin to [-1, 1].
   side_type                 side_d_ff;
   logic signed [TRIG_W-1:0] cos_d_ff, sin_d_ff, cos_d_in, sin_d_in;
   logic signed [XY_W-1:0]   xn, yn, xc, yc;

   always_comb begin
      xn = cord_side.neg ? -cord_x : cord_x;
      yn = cord_side.neg ? -cord_y : cord_y;
      xc = (xn > TRIG_ONE) ? TRIG_ONE : ((xn < -TRIG_ONE) ? -TRIG_ONE : xn);
      yc = (yn > TRIG_ONE) ? TRIG_ONE : ((yn < -TRIG_ONE) ? -TRIG_ONE : yn);
      cos_d_in = TRIG_W'(xc);
      sin_d_in = TRIG_W'(yc);
   end

   always_ff @(posedge clock) begin
      if (rdy_d && cord_out_valid) begin
         side_d_ff <= cord_side;
         cos_d_ff  <= cos_d_in;
         sin_d_ff  <= sin_d_in;
      end
   end

   // ---------------------------------------------------------------- stage E
   // Four products: w*cos, h*sin, w*sin, h*cos.
   logic signed [COORD_W-1:0] cx_e_ff, cy_e_ff;
   logic signed [PROD_W-1:0]  wc_ff, hs_ff, ws_ff, hc_ff;
   logic signed [PROD_W-1:0]  wc_in, hs_in, ws_in, hc_in;

   always_comb begin
      wc_in = PROD_W'($signed({1'b0, side_d_ff.w})) * PROD_W'(cos_d_ff);
      hs_in = PROD_W'($signed({1'b0, side_d_ff.h})) * PROD_W'(sin_d_ff);
      ws_in = PROD_W'($signed({1'b0, side_d_ff.w})) * PROD_W'(sin_d_ff);
      hc_in = PROD_W'($signed({1'b0, side_d_ff.h})) * PROD_W'(cos_d_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy_e && vd_ff) begin
         cx_e_ff <= side_d_ff.cx;
         cy_e_ff <= side_d_ff.cy;
         wc_ff   <= wc_in;
         hs_ff   <= hs_in;
         ws_ff   <= ws_in;
         hc_ff   <= hc_in;
      end
   end

   // ---------------------------------------------------------------- stage F
   // Corner offsets, rounded half up to FRAC_BITS. Each corner is rounded on
   // its own: rounding is not symmetric around zero.
   function automatic logic signed [OFS_W-1:0] round_ofs(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v + RND_HALF) >>> RND_SH;
      return OFS_W'(r);
   endfunction

   logic signed [COORD_W-1:0] cx_f_ff, cy_f_ff;
   logic signed [OFS_W-1:0]   ofx_ff [4];
   logic signed [OFS_W-1:0]   ofy_ff [4];
   logic signed [OFS_W-1:0]   ofx_in [4];
   logic signed [OFS_W-1:0]   ofy_in [4];
   logic signed [SUM_W-1:0]   a_s, b_s, c_s, d_s;

   always_comb begin
      a_s = SUM_W'(wc_ff);
      b_s = SUM_W'(hs_ff);
      c_s = SUM_W'(ws_ff);
      d_s = SUM_W'(hc_ff);
      // corner order: (-w,-h), (+w,-h), (-w,+h), (+w,+h)
      ofx_in[0] = round_ofs(b_s - a_s);
      ofx_in[1] = round_ofs(a_s + b_s);
      ofx_in[2] = round_ofs(-a_s - b_s);
      ofx_in[3] = round_ofs(a_s - b_s);
      ofy_in[0] = round_ofs(-c_s - d_s);
      ofy_in[1] = round_ofs(c_s - d_s);
      ofy_in[2] = round_ofs(d_s - c_s);
      ofy_in[3] = round_ofs(c_s + d_s);
   end

   always_ff @(posedge clock) begin
      if (rdy_f && ve_ff) begin
         cx_f_ff <= cx_e_ff;
         cy_f_ff <= cy_e_ff;
         ofx_ff  <= ofx_in;
         ofy_ff  <= ofy_in;
      end
   end

   // ---------------------------------------------------------------- stage G
   // Translate to the center and saturate each corner.
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [CORNER_W-1:0] v);
      logic signed [CORNER_W-1:0] r;
      r = (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
      return COORD_W'(r);
   endfunction

   logic signed [COORD_W-1:0] px_ff [4];
   logic signed [COORD_W-1:0] py_ff [4];
   logic signed [COORD_W-1:0] px_in [4];
   logic signed [COORD_W-1:0] py_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         px_in[k] = sat_coord(CORNER_W'(cx_f_ff) + CORNER_W'(ofx_ff[k]));
         py_in[k] = sat_coord(CORNER_W'(cy_f_ff) + CORNER_W'(ofy_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_g && vf_ff) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // ---------------------------------------------------------------- stage H
   // Min/max over the four corners; this is the output register.
   function automatic logic signed [COORD_W-1:0] min4(
      input logic signed [COORD_W-1:0] v0, v1, v2, v3);
      logic signed [COORD_W-1:0] m0, m1;
      m0 = (v1 < v0) ? v1 : v0;
      m1 = (v3 < v2) ? v3 : v2;
      return (m1 < m0) ? m1 : m0;
   endfunction

   function automatic logic signed [COORD_W-1:0] max4(
      input logic signed [COORD_W-1:0] v0, v1, v2, v3);
      logic signed [COORD_W-1:0] m0, m1;
      m0 = (v1 > v0) ? v1 : v0;
      m1 = (v3 > v2) ? v3 : v2;
      return (m1 > m0) ? m1 : m0;
   endfunction

   logic signed [COORD_W-1:0] mnx_ff, mny_ff, mxx_ff, mxy_ff;

   always_ff @(posedge clock) begin
      if (rdy_h && vg_ff) begin
         mnx_ff <= min4(px_ff[0], px_ff[1], px_ff[2], px_ff[3]);
         mny_ff <= min4(py_ff[0], py_ff[1], py_ff[2], py_ff[3]);
         mxx_ff <= max4(px_ff[0], px_ff[1], px_ff[2], px_ff[3]);
         mxy_ff <= max4(py_ff[0], py_ff[1], py_ff[2], py_ff[3]);
      end
   end

   assign rsp_tdata = {mxy_ff, mxx_ff, mny_ff, mnx_ff};

endmodule

>>> design/rrbb_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage, with a per-stage handshake.
module rrbb_cordic import rrbb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [Z_W-1:0]  in_z,
   input  side_type               in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [XY_W-1:0] out_x,
   output logic signed [XY_W-1:0] out_y,
   output side_type               out_side
);

   logic                  v_ff    [CORD_ITERS];
   logic signed [XY_W-1:0] x_ff   [CORD_ITERS];
   logic signed [XY_W-1:0] y_ff   [CORD_ITERS];
   logic signed [Z_W-1:0]  z_ff   [CORD_ITERS];
   side_type               side_ff[CORD_ITERS];
   logic                   rdy    [CORD_ITERS+1];

   assign rdy[CORD_ITERS] = out_ready;

   for (genvar gi = 0; gi < CORD_ITERS; gi++) begin : g_stage
      logic signed [XY_W-1:0] x_src, y_src, x_in, y_in;
      logic signed [Z_W-1:0]  z_src, z_in;
      side_type               side_src;
      logic                   v_src;

      if (gi == 0) begin : g_first
         assign x_src    = CORD_GAIN;
         assign y_src    = '0;
         assign z_src    = in_z;
         assign side_src = in_side;
         assign v_src    = in_valid;
      end else begin : g_next
         assign x_src    = x_ff[gi-1];
         assign y_src    = y_ff[gi-1];
         assign z_src    = z_ff[gi-1];
         assign side_src = side_ff[gi-1];
         assign v_src    = v_ff[gi-1];
      end

      assign rdy[gi] = !v_ff[gi] || rdy[gi+1];

      always_comb begin
         if (!z_src[Z_W-1]) begin
            x_in = x_src - (y_src >>> gi);
            y_in = y_src + (x_src >>> gi);
            z_in = z_src - ATAN_TAB[gi];
         end else begin
            x_in = x_src + (y_src >>> gi);
            y_in = y_src - (x_src >>> gi);
            z_in = z_src + ATAN_TAB[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[gi] <= 1'b0;
         end else if (rdy[gi]) begin
            v_ff[gi] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[gi] && v_src) begin
            x_ff[gi]    <= x_in;
            y_ff[gi]    <= y_in;
            z_ff[gi]    <= z_in;
            side_ff[gi] <= side_src;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[CORD_ITERS-1];
   assign out_x     = x_ff[CORD_ITERS-1];
   assign out_y     = y_ff[CORD_ITERS-1];
   assign out_side  = side_ff[CORD_ITERS-1];

endmodule
